[design/dflc_pkg.sv]
// Shared constants, types and helpers for the dilated FIR line convolver.
// No dependencies; the top level, sequencer, MAC and result stage import it.
package dflc_pkg;

  localparam int MAX_LEN     = 64;
  localparam int MAX_HALF    = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int SB          = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;

  localparam int VAL_W   = 16;
  localparam int TAP_W   = 16;
  localparam int FRAC    = 14;
  localparam int TIDX_W  = 5;
  localparam int HW_W    = 4;
  localparam int DIL_W   = 5;
  localparam int MODE_W  = 3;
  localparam int REG_W   = 2;
  localparam int CFG_W   = 8;
  localparam int OIDX_W  = 6;
  localparam int DIL_MAX = 16;

  localparam int KSLOTS  = 2 * MAX_HALF + 1;
  localparam int KADDR_W = $clog2(KSLOTS);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int K_W     = $clog2(MAX_LEN + MAX_HALF * DIL_MAX) + 2;

  localparam int PROD_W  = SB + TAP_W;
  localparam int ACC_W   = PROD_W + $clog2(KSLOTS);
  localparam int WS_W    = TAP_W + $clog2(KSLOTS);
  localparam int NUM_W   = ACC_W + 1;
  localparam int QB      = SB - 1;
  localparam int QCNT_W  = $clog2(QB);

  localparam logic OP_TAP    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [REG_W-1:0] REG_HALF_WIDTH  = REG_W'(0);
  localparam logic [REG_W-1:0] REG_DILATION    = REG_W'(1);
  localparam logic [REG_W-1:0] REG_BORDER_MODE = REG_W'(2);

  localparam logic [MODE_W-1:0] MODE_CLAMP      = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_ZERO_LEFT  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_ZERO_RIGHT = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_ZERO       = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_PERIODIC   = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_NORM       = MODE_W'(5);

  typedef struct packed {
    logic [HW_W-1:0]   hw;
    logic [DIL_W-1:0]  dil;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  typedef struct packed {
    logic vld;
    logic take;
    logic fin;
  } tap_issue_t;

  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] acc;
    logic signed [WS_W-1:0]  ws;
  } mac_res_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
  } post_res_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] pos;
    logic              last_pos;
  } seq_stat_t;

  function automatic logic [HW_W-1:0] eff_w(input logic [HW_W-1:0] hw);
    eff_w = (int'(hw) > MAX_HALF) ? HW_W'(MAX_HALF) : hw;
  endfunction

  function automatic logic [DIL_W-1:0] eff_d(input logic [DIL_W-1:0] dil);
    eff_d = (dil == '0) ? DIL_W'(1) : dil;
  endfunction

  function automatic logic is_norm(input logic [MODE_W-1:0] mode);
    is_norm = (mode >= MODE_NORM);
  endfunction

endpackage

[design/dilated_fir_line_convolver.sv]
// Top level of the dilated FIR line convolver: command and config ports,
// sample and tap RAMs, sequencer, MAC and result stage. Depends on dflc_pkg.
//
//   channel  dir  handshake                words carried
//   command  in   start, busy              op, tap_index, value, last
//   config   in   cfg_valid, cfg_ready     cfg_index, cfg_data
//   result   out  strobe (one cycle each)  out_value, out_index, out_last
//
// A tap write or a sample push without last leaves busy low. The final push
// sets up the modulus, then each position makes one tap read per cycle from
// the sample RAM into the single MAC. Normalised mode adds the divider.
// rst is synchronous; tap and sample RAMs hold no reset value.
// Results cannot be stalled; one strobe per position, in order.
module dilated_fir_line_convolver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [dflc_pkg::TIDX_W-1:0]   tap_index,
  input  logic signed [dflc_pkg::VAL_W-1:0] value,
  input  logic                          last,
  output logic                          strobe,
  output logic signed [dflc_pkg::VAL_W-1:0] out_value,
  output logic [dflc_pkg::OIDX_W-1:0]   out_index,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dflc_pkg::REG_W-1:0]    cfg_index,
  input  logic [dflc_pkg::CFG_W-1:0]    cfg_data
);
  import dflc_pkg::*;

  cfg_t               cfg;
  logic [LEN_W-1:0]   count;
  logic               accept;
  logic               push;
  logic               s_we;
  logic               k_we;
  logic               launch;
  logic [LEN_W-1:0]   launch_len;

  tap_issue_t         issue;
  logic [ADDR_W-1:0]  sample_raddr;
  logic [KADDR_W-1:0] kernel_raddr;
  logic [SB-1:0]      sample_q;
  logic [TAP_W-1:0]   tap_q;
  seq_stat_t          stat;
  mac_res_t           mres;
  post_res_t          pres;

  assign busy      = stat.busy;
  assign cfg_ready = !stat.busy;
  assign accept    = start && !busy;
  assign push      = accept && (op == OP_SAMPLE);
  assign s_we      = push && (count < LEN_W'(MAX_LEN));
  assign k_we      = accept && (op == OP_TAP) && (int'(tap_index) < KSLOTS);
  assign launch    = push && last;
  assign launch_len = s_we ? count + LEN_W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (launch) begin
      count <= '0;
    end else if (s_we) begin
      count <= count + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hw   <= HW_W'(1);
      cfg.dil  <= DIL_W'(1);
      cfg.mode <= MODE_CLAMP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_WIDTH:  cfg.hw   <= cfg_data[HW_W-1:0];
        REG_DILATION:    cfg.dil  <= cfg_data[DIL_W-1:0];
        REG_BORDER_MODE: cfg.mode <= cfg_data[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dflc_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_LEN)
  ) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (value[SB-1:0]),
    .raddr (sample_raddr),
    .rdata (sample_q)
  );

  dflc_ram #(
    .WIDTH (TAP_W),
    .DEPTH (KSLOTS)
  ) u_kernel_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (KADDR_W'(tap_index)),
    .wdata (value),
    .raddr (kernel_raddr),
    .rdata (tap_q)
  );

  dflc_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .launch       (launch),
    .launch_len   (launch_len),
    .post_done    (pres.done),
    .issue        (issue),
    .sample_raddr (sample_raddr),
    .kernel_raddr (kernel_raddr),
    .stat         (stat)
  );

  dflc_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .sample_q ($signed(sample_q)),
    .tap_q    ($signed(tap_q)),
    .res      (mres)
  );

  dflc_post u_post (
    .clk  (clk),
    .rst  (rst),
    .res  (mres),
    .norm (is_norm(cfg.mode)),
    .out  (pres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= pres.done;
      if (pres.done) begin
        out_value <= pres.value;
        out_index <= OIDX_W'(stat.pos);
        out_last  <= stat.last_pos;
      end
    end
  end

endmodule

[design/dflc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dflc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/dflc_seq.sv]
// Line sequencer: modulus setup, tap address generation with border handling,
// per-position stepping. Depends on dflc_pkg.
module dflc_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  dflc_pkg::cfg_t              cfg,
  input  logic                        launch,
  input  logic [dflc_pkg::LEN_W-1:0]  launch_len,
  input  logic                        post_done,
  output dflc_pkg::tap_issue_t        issue,
  output logic [dflc_pkg::ADDR_W-1:0] sample_raddr,
  output logic [dflc_pkg::KADDR_W-1:0] kernel_raddr,
  output dflc_pkg::seq_stat_t         stat
);
  import dflc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DMOD, S_WMOD, S_TAPS, S_WAIT} state_t;

  state_t                   state;
  logic [LEN_W-1:0]         n_len;
  logic [DIL_W-1:0]         dm;
  logic [ADDR_W-1:0]        rem_r;
  logic [HW_W-1:0]          cnt;
  logic [ADDR_W-1:0]        pos;
  logic [KADDR_W-1:0]       t;
  logic signed [K_W-1:0]    kstart;
  logic signed [K_W-1:0]    k;
  logic [ADDR_W-1:0]        pstart;
  logic [ADDR_W-1:0]        p;

  logic [HW_W-1:0]          w_eff;
  logic [DIL_W-1:0]         d_eff;
  logic [HW_W+DIL_W-1:0]    wd;
  logic signed [K_W-1:0]    kinit;
  logic signed [K_W-1:0]    d_k;
  logic signed [K_W-1:0]    n_k;
  logic                     k_lo;
  logic                     k_hi;
  logic                     clamp_l;
  logic                     clamp_r;
  logic                     periodic;
  logic                     fin;
  logic                     last_pos;
  logic [ADDR_W-1:0]        p_next;
  logic [ADDR_W-1:0]        pstart_next;
  logic [ADDR_W-1:0]        rem_next;
  logic [ADDR_W-1:0]        pinit;

  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [LEN_W-1:0]  b,
                                                 input logic [LEN_W-1:0]  n);
    logic [LEN_W:0] s;
    s = (LEN_W+1)'(a) + (LEN_W+1)'(b);
    if (s >= (LEN_W+1)'(n)) begin
      s = s - (LEN_W+1)'(n);
    end
    wrap_add = s[ADDR_W-1:0];
  endfunction

  assign w_eff  = eff_w(cfg.hw);
  assign d_eff  = eff_d(cfg.dil);
  assign wd     = (HW_W+DIL_W)'(w_eff) * (HW_W+DIL_W)'(d_eff);
  assign kinit  = K_W'(0) - K_W'(wd);
  assign d_k    = K_W'(d_eff);
  assign n_k    = K_W'(n_len);
  assign k_lo   = k[K_W-1];
  assign k_hi   = !k_lo && (k >= n_k);

  assign clamp_l  = (cfg.mode == MODE_CLAMP) || (cfg.mode == MODE_ZERO_RIGHT);
  assign clamp_r  = (cfg.mode == MODE_CLAMP) || (cfg.mode == MODE_ZERO_LEFT);
  assign periodic = (cfg.mode == MODE_PERIODIC);

  assign fin      = (t == KADDR_W'({w_eff, 1'b0}));
  assign last_pos = ((LEN_W)'(pos) == n_len - LEN_W'(1));

  assign p_next      = wrap_add(p, LEN_W'(dm), n_len);
  assign pstart_next = wrap_add(pstart, LEN_W'(1), n_len);
  assign rem_next    = wrap_add(rem_r, LEN_W'(dm), n_len);
  assign pinit       = (rem_r == '0) ? '0 : ADDR_W'(n_len - LEN_W'(rem_r));

  always_comb begin
    issue.vld    = (state == S_TAPS);
    issue.fin    = fin;
    issue.take   = 1'b1;
    sample_raddr = k[ADDR_W-1:0];
    if (k_lo || k_hi) begin
      if (periodic) begin
        sample_raddr = p;
      end else if (k_lo) begin
        sample_raddr = '0;
        issue.take   = clamp_l;
      end else begin
        sample_raddr = ADDR_W'(n_len - LEN_W'(1));
        issue.take   = clamp_r;
      end
    end
  end

  assign kernel_raddr  = t;
  assign stat.busy     = (state != S_IDLE);
  assign stat.pos      = pos;
  assign stat.last_pos = last_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (launch) begin
            n_len  <= launch_len;
            dm     <= d_eff;
            rem_r  <= '0;
            cnt    <= w_eff;
            pos    <= '0;
            kstart <= kinit;
            state  <= S_DMOD;
          end
        end
        S_DMOD: begin
          if (LEN_W'(dm) >= n_len) begin
            dm <= dm - DIL_W'(n_len);
          end else begin
            state <= S_WMOD;
          end
        end
        S_WMOD: begin
          if (cnt == '0) begin
            pstart <= pinit;
            p      <= pinit;
            k      <= kstart;
            t      <= '0;
            state  <= S_TAPS;
          end else begin
            rem_r <= rem_next;
            cnt   <= cnt - HW_W'(1);
          end
        end
        S_TAPS: begin
          k <= k + d_k;
          p <= p_next;
          t <= t + KADDR_W'(1);
          if (fin) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (post_done) begin
            if (last_pos) begin
              state <= S_IDLE;
            end else begin
              pos    <= pos + ADDR_W'(1);
              kstart <= kstart + K_W'(1);
              k      <= kstart + K_W'(1);
              pstart <= pstart_next;
              p      <= pstart_next;
              t      <= '0;
              state  <= S_TAPS;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[design/dflc_mac.sv]
// Shared multiply-accumulate: registered product, then tap-weight and
// product sums per line position. Depends on dflc_pkg.
module dflc_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  dflc_pkg::tap_issue_t          issue,
  input  logic signed [dflc_pkg::SB-1:0]    sample_q,
  input  logic signed [dflc_pkg::TAP_W-1:0] tap_q,
  output dflc_pkg::mac_res_t            res
);
  import dflc_pkg::*;

  tap_issue_t               iss1;
  tap_issue_t               iss2;
  logic signed [PROD_W-1:0] prod;
  logic signed [TAP_W-1:0]  tw;
  logic signed [ACC_W-1:0]  acc;
  logic signed [WS_W-1:0]   ws;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [WS_W-1:0]   ws_next;

  assign acc_next = acc + ACC_W'(prod);
  assign ws_next  = ws + WS_W'(tw);

  always_ff @(posedge clk) begin
    if (rst) begin
      iss1    <= '0;
      iss2    <= '0;
      acc     <= '0;
      ws      <= '0;
      res.vld <= 1'b0;
    end else begin
      iss1 <= issue;
      iss2 <= iss1;
      if (iss1.vld && iss1.take) begin
        prod <= sample_q * tap_q;
        tw   <= tap_q;
      end else begin
        prod <= '0;
        tw   <= '0;
      end
      res.vld <= iss2.vld && iss2.fin;
      if (iss2.vld) begin
        if (iss2.fin) begin
          res.acc <= acc_next;
          res.ws  <= ws_next;
          acc     <= '0;
          ws      <= '0;
        end else begin
          acc <= acc_next;
          ws  <= ws_next;
        end
      end
    end
  end

endmodule

[design/dflc_post.sv]
// Result stage: round and saturate, or normalise by the used tap weight
// through a restoring divider. Depends on dflc_pkg.
module dflc_post (
  input  logic                clk,
  input  logic                rst,
  input  dflc_pkg::mac_res_t  res,
  input  logic                norm,
  output dflc_pkg::post_res_t out
);
  import dflc_pkg::*;

  localparam int Y_W = ACC_W + 1 - FRAC;
  localparam int RND = 1 << (FRAC - 1);
  localparam logic signed [VAL_W-1:0] S_MAX = VAL_W'((1 << (SB - 1)) - 1);
  localparam logic signed [VAL_W-1:0] S_MIN = -S_MAX - VAL_W'(1);

  typedef enum logic [1:0] {P_IDLE, P_CHECK, P_DIV} state_t;

  state_t              state;
  logic [NUM_W-1:0]    rem;
  logic [NUM_W-1:0]    den;
  logic [QB-1:0]       q;
  logic [QCNT_W-1:0]   cnt;
  logic                neg;

  logic [ACC_W-1:0]      acc_mag;
  logic [WS_W-1:0]       ws_mag;
  logic signed [ACC_W:0] rnd;
  logic signed [Y_W-1:0] y;
  logic                  ge;
  logic [QB-1:0]         q_next;

  assign acc_mag = res.acc[ACC_W-1] ? ACC_W'(-res.acc) : ACC_W'(res.acc);
  assign ws_mag  = res.ws[WS_W-1] ? WS_W'(-res.ws) : WS_W'(res.ws);
  assign rnd     = (ACC_W+1)'(res.acc) + (ACC_W+1)'(RND);
  assign y       = rnd[ACC_W:FRAC];
  assign ge      = (rem >= den);
  assign q_next  = {q[QB-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= P_IDLE;
      out.done <= 1'b0;
    end else begin
      out.done <= 1'b0;
      case (state)
        P_IDLE: begin
          if (res.vld) begin
            if (!norm) begin
              if (y > Y_W'(S_MAX)) begin
                out.value <= S_MAX;
              end else if (y < Y_W'(S_MIN)) begin
                out.value <= S_MIN;
              end else begin
                out.value <= VAL_W'(y);
              end
              out.done <= 1'b1;
            end else if (res.ws == '0) begin
              out.value <= '0;
              out.done  <= 1'b1;
            end else begin
              neg   <= res.acc[ACC_W-1] ^ res.ws[WS_W-1];
              rem   <= {acc_mag, 1'b0} + NUM_W'(ws_mag);
              den   <= NUM_W'(ws_mag) << (QB + 1);
              state <= P_CHECK;
            end
          end
        end
        P_CHECK: begin
          if (ge) begin
            out.value <= neg ? S_MIN : S_MAX;
            out.done  <= 1'b1;
            state     <= P_IDLE;
          end else begin
            den   <= den >> 1;
            q     <= '0;
            cnt   <= QCNT_W'(QB - 1);
            state <= P_DIV;
          end
        end
        P_DIV: begin
          if (ge) begin
            rem <= rem - den;
          end
          q   <= q_next;
          den <= den >> 1;
          cnt <= cnt - QCNT_W'(1);
          if (cnt == '0) begin
            out.value <= neg ? -VAL_W'(q_next) : VAL_W'(q_next);
            out.done  <= 1'b1;
            state     <= P_IDLE;
          end
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

[design/dflc_checker.sv]
// Port-level checks on the convolver's command and result timing, bound to
// the top level. Depends on dilated_fir_line_convolver.
module dflc_port_props (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic op,
  input logic last,
  input logic strobe,
  input logic out_last
);

  a_last_launches: assert property (@(posedge clk) disable iff (rst)
    start && !busy && op && last |=> busy)
    else $error("final sample did not start the line");

  a_plain_stays_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !(op && last) |=> !busy)
    else $error("busy raised without a final sample");

  a_final_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && out_last |-> !busy)
    else $error("still busy after final word");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !out_last |-> busy)
    else $error("idle before final word of the line");

endmodule

bind dilated_fir_line_convolver dflc_port_props u_dflc_port_props (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .op       (op),
  .last     (last),
  .strobe   (strobe),
  .out_last (out_last)
);
